@@ sv/grma_pkg.sv @@
// grma_pkg: shared types and constants for the gravity-removed motion accel block
// no dependencies
`default_nettype none
package grma_pkg;

    localparam logic signed [31:0] GRAVITY_Q16 = 32'sd642580;
    localparam logic [15:0] TAU_RESET = 16'd8500;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAT,
        ST_FILT,
        ST_DIV,
        ST_EARTH,
        ST_OUT
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       mat_step;
        logic       filt_step;
        logic       div_start;
        logic       div_step;
        logic       div_done;
        logic       earth_step;
        logic [3:0] idx;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic den_zero;
    } status_t;

endpackage
`default_nettype wire

@@ sv/grma_ctrl.sv @@
// grma_ctrl: sequencer for the gravity-removed motion accel block
// depends on grma_pkg
`default_nettype none
module grma_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_fire,
    input  wire logic              out_fire,
    input  wire grma_pkg::status_t status,
    output grma_pkg::cmd_t         cmd,
    output logic                   busy,
    output logic                   result_valid
);
    import grma_pkg::*;

    state_t     state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;
    logic [1:0] axis_reg, axis_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            axis_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            axis_reg  <= axis_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        axis_next    = axis_reg;
        cmd          = '0;
        cmd.idx      = cnt_reg[3:0];
        busy         = (state_reg != ST_IDLE);
        result_valid = (state_reg == ST_OUT);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MAT;
                    cnt_next   = '0;
                end
            end
            ST_MAT:
            begin
                // ten quaternion products, one per cycle
                cmd.mat_step = 1'b1;
                if (cnt_reg == 7'd9)
                begin
                    cnt_next   = '0;
                    axis_next  = '0;
                    state_next = ST_FILT;
                end
                else
                    cnt_next = cnt_reg + 7'd1;
            end
            ST_FILT:
            begin
                // per axis: gravity-removed diff, numerator, divider setup
                cmd.filt_step = 1'b1;
                cmd.idx       = {cnt_reg[1:0], axis_reg};
                if (cnt_reg == 7'd2)
                begin
                    cnt_next = '0;
                    if (status.den_zero)
                    begin
                        cmd.div_done = 1'b1;
                        if (axis_reg == 2'd2)
                            state_next = ST_EARTH;
                        else
                            axis_next = axis_reg + 2'd1;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end
                end
                else
                    cnt_next = cnt_reg + 7'd1;
            end
            ST_DIV:
            begin
                // 64 quotient bits, then the result is written back
                cmd.idx = {2'd0, axis_reg};
                if (cnt_reg == 7'd64)
                begin
                    cmd.div_done = 1'b1;
                    cnt_next     = '0;
                    if (axis_reg == 2'd2)
                        state_next = ST_EARTH;
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = ST_FILT;
                    end
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    cnt_next     = cnt_reg + 7'd1;
                end
            end
            ST_EARTH:
            begin
                // nine matrix terms, each row saturated into the output after its third term
                cmd.earth_step = 1'b1;
                if (cnt_reg == 7'd11)
                begin
                    cnt_next   = '0;
                    state_next = ST_OUT;
                end
                else
                    cnt_next = cnt_reg + 7'd1;
            end
            ST_OUT:
            begin
                if (out_fire)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // result is only shown while busy; load starts the matrix phase; divide count stays in range
    a_valid_out: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result valid while idle");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_MAT))
        else $error("load did not start matrix phase");
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg <= 7'd64))
        else $error("divider count overrun");

endmodule
`default_nettype wire

@@ sv/grma_dp.sv @@
// grma_dp: datapath with multipliers, serial divider and filter state
// depends on grma_pkg
`default_nettype none
module grma_dp
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire grma_pkg::cmd_t     cmd,
    input  wire logic [15:0]        tau,
    input  wire logic [239:0]       in_data,
    output grma_pkg::status_t       status,
    output logic [191:0]            out_data
);
    import grma_pkg::*;

    logic signed [31:0] acc_reg [3];
    logic signed [31:0] q_reg [4];
    logic [15:0]        dt_reg, tau_reg;
    logic signed [33:0] p_reg [10];
    logic signed [31:0] filt_reg [3];
    logic signed [63:0] diff_reg;
    logic signed [63:0] num_reg;
    logic [63:0]        rem_reg, quo_reg;
    logic               neg_reg;
    logic signed [63:0] earth_acc_reg;
    logic signed [31:0] earth_reg [3];
    logic [1:0]         eri_reg;

    // floor(c*v / 2^30) with c in [-2^35, 2^35)
    function automatic logic signed [63:0] mul_q30(input logic signed [35:0] c,
                                                  input logic signed [31:0] v);
        logic signed [71:0] pr;
        begin
            pr = 72'(c) * 72'(v);
            return 64'(pr >>> 30);
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        begin
            if (x > 64'sd2147483647)
                return 32'sh7fffffff;
            else if (x < -64'sd2147483648)
                return 32'sh80000000;
            else
                return x[31:0];
        end
    endfunction

    // product pair selection for the matrix phase
    logic signed [31:0] qa, qb;
    always_comb
    begin
        qa = q_reg[0];
        qb = q_reg[0];
        unique case (cmd.idx)
            4'd0: begin qa = q_reg[0]; qb = q_reg[0]; end
            4'd1: begin qa = q_reg[1]; qb = q_reg[1]; end
            4'd2: begin qa = q_reg[2]; qb = q_reg[2]; end
            4'd3: begin qa = q_reg[3]; qb = q_reg[3]; end
            4'd4: begin qa = q_reg[0]; qb = q_reg[1]; end
            4'd5: begin qa = q_reg[0]; qb = q_reg[2]; end
            4'd6: begin qa = q_reg[0]; qb = q_reg[3]; end
            4'd7: begin qa = q_reg[1]; qb = q_reg[2]; end
            4'd8: begin qa = q_reg[1]; qb = q_reg[3]; end
            4'd9: begin qa = q_reg[2]; qb = q_reg[3]; end
            default: begin qa = q_reg[0]; qb = q_reg[0]; end
        endcase
    end
    logic signed [63:0] qprod;
    assign qprod = (64'(qa) * 64'(qb)) >>> 30;

    // rotation matrix entries, Q.30 (index p: 0 00,1 11,2 22,3 33,4 01,5 02,6 03,7 12,8 13,9 23)
    localparam logic signed [35:0] HALF = 36'sd536870912;
    logic signed [35:0] r [9];
    always_comb
    begin
        r[0] = 36'sd2 * (HALF - 36'(p_reg[2]) - 36'(p_reg[3]));
        r[1] = 36'sd2 * (36'(p_reg[7]) - 36'(p_reg[6]));
        r[2] = 36'sd2 * (36'(p_reg[8]) + 36'(p_reg[5]));
        r[3] = 36'sd2 * (36'(p_reg[7]) + 36'(p_reg[6]));
        r[4] = 36'sd2 * (HALF - 36'(p_reg[1]) - 36'(p_reg[3]));
        r[5] = 36'sd2 * (36'(p_reg[9]) - 36'(p_reg[4]));
        r[6] = 36'sd2 * (36'(p_reg[8]) - 36'(p_reg[5]));
        r[7] = 36'sd2 * (36'(p_reg[9]) + 36'(p_reg[4]));
        r[8] = 36'sd2 * (HALF - 36'(p_reg[1]) - 36'(p_reg[2]));
    end

    logic [1:0]  axis, phase;
    assign axis  = cmd.idx[1:0];
    assign phase = cmd.idx[3:2];
    logic [16:0] den;
    assign den = 17'(tau_reg) + 17'(dt_reg);
    assign status.den_zero = (den == 17'd0);

    // earth phase term selection
    logic [3:0]         ecnt_reg;
    logic [1:0]         erow, ecol;
    logic signed [35:0] ecoef;
    always_comb
    begin
        erow  = 2'd0;
        ecol  = 2'd0;
        unique case (ecnt_reg)
            4'd0: begin erow = 2'd0; ecol = 2'd0; end
            4'd1: begin erow = 2'd0; ecol = 2'd1; end
            4'd2: begin erow = 2'd0; ecol = 2'd2; end
            4'd3: begin erow = 2'd1; ecol = 2'd0; end
            4'd4: begin erow = 2'd1; ecol = 2'd1; end
            4'd5: begin erow = 2'd1; ecol = 2'd2; end
            4'd6: begin erow = 2'd2; ecol = 2'd0; end
            4'd7: begin erow = 2'd2; ecol = 2'd1; end
            4'd8: begin erow = 2'd2; ecol = 2'd2; end
            default: begin erow = 2'd0; ecol = 2'd0; end
        endcase
        ecoef = r[4'(erow) * 4'd3 + 4'(ecol)];
    end

    // divider step: restoring on magnitude
    logic [64:0] rem_sh;
    logic [64:0] rem_sub;
    assign rem_sh  = {rem_reg, quo_reg[63]};
    assign rem_sub = rem_sh - 65'(den);

    logic signed [63:0] fin_q;
    always_comb
    begin
        if (status.den_zero)
            fin_q = diff_reg;
        else if (neg_reg)
            fin_q = -$signed(quo_reg) - 64'sd1;
        else
            fin_q = $signed(quo_reg);
    end

    // datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                filt_reg[i] <= '0;
            ecnt_reg <= '0;
        end
        else
        begin
            if (cmd.load)
                ecnt_reg <= '0;
            if (cmd.earth_step && ecnt_reg < 4'd9)
                ecnt_reg <= ecnt_reg + 4'd1;
            if (cmd.div_done)
                filt_reg[axis] <= sat32(fin_q);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < 3; i++)
                acc_reg[i] <= in_data[32*i +: 32];
            for (int i = 0; i < 4; i++)
                q_reg[i] <= in_data[96 + 32*i +: 32];
            dt_reg        <= in_data[239:224];
            tau_reg       <= tau;
            earth_acc_reg <= '0;
            eri_reg       <= '0;
        end
        if (cmd.mat_step)
            p_reg[cmd.idx] <= 34'(qprod);
        if (cmd.filt_step)
        begin
            unique case (phase)
                2'd0: diff_reg <= 64'(acc_reg[axis]) - mul_q30(r[6 + axis], GRAVITY_Q16);
                2'd1: num_reg <= diff_reg * 64'($signed({1'b0, dt_reg}))
                                 + 64'(filt_reg[axis]) * 64'($signed({1'b0, tau_reg}));
                default:
                begin
                    neg_reg <= num_reg[63];
                    quo_reg <= num_reg[63] ? 64'(-(num_reg + 64'sd1)) : 64'(num_reg);
                    rem_reg <= '0;
                end
            endcase
        end
        if (cmd.div_step)
        begin
            if (!rem_sub[64])
                rem_reg <= rem_sub[63:0];
            else
                rem_reg <= rem_sh[63:0];
            quo_reg <= {quo_reg[62:0], ~rem_sub[64]};
        end
        if (cmd.earth_step)
        begin
            if (ecnt_reg < 4'd9)
            begin
                if (ecol == 2'd0)
                    earth_acc_reg <= mul_q30(ecoef, filt_reg[0]);
                else
                    earth_acc_reg <= earth_acc_reg + mul_q30(ecoef, filt_reg[ecol]);
                if (ecol == 2'd2)
                    eri_reg <= erow;
            end
            if (ecnt_reg != 4'd0 && (ecnt_reg == 4'd3 || ecnt_reg == 4'd6
                                     || ecnt_reg == 4'd9))
                earth_reg[eri_reg] <= sat32(earth_acc_reg);
        end
    end

    assign out_data = {earth_reg[2], earth_reg[1], earth_reg[0],
                       filt_reg[2], filt_reg[1], filt_reg[0]};

endmodule
`default_nettype wire

@@ sv/gravity_removed_motion_accel_top.sv @@
// gravity_removed_motion_accel_top: stream wrapper, config register, ctrl and datapath
// depends on grma_pkg, grma_ctrl, grma_dp
// an input transfer is followed by the matrix products, then per axis the filter setup
//   and a serial divide, then the earth steps, then the result transfer; the divides
//   are skipped when tau plus elapsed time is zero
// a new input waits for the last result transfer; the divider makes one bit per cycle
// reset: filter state cleared, tau register set to 8500 us
`default_nettype none
module gravity_removed_motion_accel_top
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // accel_x, accel_y, accel_z, quat_w, quat_x, quat_y, quat_z, elapsed_us
    input  wire logic [239:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // motion_body_x/y/z, motion_earth_x/y/z
    output logic [191:0]      m_axis_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [1:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import grma_pkg::*;

    logic [15:0] tau_reg;
    cmd_t        cmd;
    status_t     status;
    logic        busy;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {16'd0, tau_reg} : 32'd0;

    // config register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tau_reg <= TAU_RESET;
        else if (psel && penable && pwrite && paddr == 2'd0)
            tau_reg <= pwdata[15:0];
    end

    assign s_axis_tready = !busy;

    grma_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_fire      (s_axis_tvalid && s_axis_tready),
        .out_fire     (m_axis_tvalid && m_axis_tready),
        .status       (status),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (m_axis_tvalid)
    );

    grma_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .tau      (tau_reg),
        .in_data  (s_axis_tdata),
        .status   (status),
        .out_data (m_axis_tdata)
    );

endmodule
`default_nettype wire
